@@ rtl/text_console_writer_core_macros.svh @@
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check prop at every rising edge while out of reset.
`define TCW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("console writer check failed");

// Check prop at every rising edge, reset included.
`define TCW_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("console writer check failed");

`else

`define TCW_ASSERT(label, clk, rst_n, prop)
`define TCW_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ rtl/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

    // Operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCROLL = 5'b00100,
        ST_PUT    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    // One screen cell: attribute in the high byte, character in the low byte
    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
    } cell_t;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register word index (paddr bit 2)
    localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;

    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int RD_COL_W  = 7;
    localparam int RD_ROW_W  = 5;
    localparam int OP_W      = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

endpackage

`default_nettype wire

@@ rtl/tcw_cfg.sv @@
// APB register block holding the text attribute.
`default_nettype none

module tcw_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [tcw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [tcw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic      [tcw_pkg::ATTR_W-1:0]       text_attribute
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic              wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTRIBUTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (wr_hit)
        begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TEXT_ATTRIBUTE)
        begin
            prdata = {{(APB_DATA_W-ATTR_W){1'b0}}, attr_reg};
        end
    end

    assign text_attribute = attr_reg;

endmodule

`default_nettype wire

@@ rtl/tcw_ram.sv @@
// Screen cell memory: one write port, one read port, registered read data.
`default_nettype none

module tcw_ram #(
    parameter int DEPTH  = 1920,
    parameter int ADDR_W = 11
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [ADDR_W-1:0]     waddr,
    input  wire tcw_pkg::cell_t        wdata,
    input  wire logic                  re,
    input  wire logic [ADDR_W-1:0]     raddr,
    output tcw_pkg::cell_t             rdata
);
    import tcw_pkg::*;

    cell_t mem [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/text_console_writer_core.sv @@
// Text console writer top level: command stream in, cell and cursor report out.
//
// A ROWS x COLUMNS text screen kept in one synchronous cell memory (char in
// the low byte, attribute in the high byte) plus a cursor. Each command beat
// on the slave stream (op in s_tuser) produces exactly one report beat on the
// master stream carrying the read cell (zero unless op is read) and the
// cursor after the command. A printable character, a newline, a read or an
// unused op is accepted in the idle state, then its report is loaded.
// A printable character at column 0 of the last row first scrolls the screen:
// a pipelined sweep reads row r+1 and writes its characters to row r with the
// current text attribute, one cell per cycle through the single memory write
// port, then the character is written. Clear writes zero to every cell, one
// per cycle. After reset the same sweep clears the memory before s_tready
// rises; APB writes are taken throughout. The report register lets the next
// command be accepted while the previous report waits on m_tready. Only
// cursor_row's low five bits are reported, and reads beyond row 31 or outside
// the screen return a zero cell.
`default_nettype none

`include "text_console_writer_core_macros.svh"

module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Command stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [7:0] char_code, [14:8] read_column, [19:15] read_row, [23:20] zero
    input  wire logic [tcw_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] op
    input  wire logic [tcw_pkg::OP_W-1:0]          s_tuser,
    // Report stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] cell_char, [15:8] cell_attribute, [22:16] cursor_column,
    // [27:23] cursor_row, [31:28] zero
    output logic      [tcw_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tcw_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [tcw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);
    import tcw_pkg::*;

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int MOVE      = CELLS - COLUMNS;      // cells shifted up by a scroll
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS; // first cell of the last row
    localparam int AW        = $clog2(CELLS);
    localparam int CW        = AW + 1;               // sweep counter, holds CELLS
    localparam int XW        = $clog2(COLUMNS);
    localparam int XW1       = XW + 1;
    localparam int YW        = $clog2(ROWS);

    // Unpack the command beat
    logic [CHAR_W-1:0]   in_char;
    logic [RD_COL_W-1:0] in_col;
    logic [RD_ROW_W-1:0] in_row;
    op_t                 in_op;

    assign in_char = s_tdata[7:0];
    assign in_col  = s_tdata[14:8];
    assign in_row  = s_tdata[19:15];
    assign in_op   = op_t'(s_tuser);

    // Attribute register
    logic [ATTR_W-1:0] text_attribute;

    tcw_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .text_attribute (text_attribute)
    );

    // Cell memory
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    cell_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    cell_t         mem_rdata;

    tcw_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer state
    state_t            state_reg,    state_next;
    logic [CW-1:0]     cnt_reg,      cnt_next;
    logic [XW-1:0]     cursor_x_reg, cursor_x_next;
    logic [YW-1:0]     cursor_y_reg, cursor_y_next;
    logic [CHAR_W-1:0] code_reg,     code_next;
    logic              clr_op_reg,   clr_op_next;
    logic              rd_hit_reg,   rd_hit_next;
    logic              rd_pend_reg,  rd_pend_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    // Cursor moves from the current position
    logic          last_row;
    logic          is_newline;
    logic [YW-1:0] nl_y;
    logic [XW-1:0] adv_x;
    logic [YW-1:0] adv_y;
    logic [AW-1:0] cursor_addr;
    logic [AW-1:0] read_addr;
    logic          read_in_range;
    cell_t         report_cell;

    assign last_row   = (cursor_y_reg == YW'(ROWS - 1));
    assign is_newline = (in_char == CHAR_LF) || (in_char == CHAR_CR);
    assign nl_y       = last_row ? cursor_y_reg : cursor_y_reg + YW'(1);

    always_comb
    begin
        if (XW1'(cursor_x_reg) + XW1'(1) == XW1'(COLUMNS))
        begin
            adv_x = '0;
            adv_y = nl_y;
        end
        else
        begin
            adv_x = cursor_x_reg + XW'(1);
            adv_y = cursor_y_reg;
        end
    end

    assign cursor_addr   = AW'(AW'(cursor_y_reg) * AW'(COLUMNS) + AW'(cursor_x_reg));
    assign read_addr     = AW'(AW'(in_row) * AW'(COLUMNS) + AW'(in_col));
    assign read_in_range = ({1'b0, in_col} < 8'(COLUMNS)) && ({2'b00, in_row} < 7'(ROWS));
    assign report_cell   = rd_hit_reg ? mem_rdata : cell_t'('0);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        code_next     = code_reg;
        clr_op_next   = clr_op_reg;
        rd_hit_next   = rd_hit_reg;
        rd_pend_next  = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_data_next = out_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one cell a cycle
                mem_we    = 1'b1;
                mem_waddr = AW'(cnt_reg);
                if (cnt_reg == CW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = clr_op_reg ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rd_hit_next = 1'b0;
                    state_next  = ST_FINISH;
                    case (in_op)
                        OP_PUT:
                        begin
                            if (is_newline)
                            begin
                                cursor_x_next = '0;
                                cursor_y_next = nl_y;
                            end
                            else if (cursor_x_reg == '0 && last_row)
                            begin
                                // Lazy scroll before writing at the last row
                                code_next  = in_char;
                                cnt_next   = '0;
                                state_next = ST_SCROLL;
                            end
                            else
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = cursor_addr;
                                mem_wdata     = '{attr: text_attribute, ch: in_char};
                                cursor_x_next = adv_x;
                                cursor_y_next = adv_y;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cursor_x_next = '0;
                            cursor_y_next = '0;
                            cnt_next      = '0;
                            clr_op_next   = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        OP_READ:
                        begin
                            if (read_in_range)
                            begin
                                mem_re      = 1'b1;
                                mem_raddr   = read_addr;
                                rd_hit_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            rd_hit_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_SCROLL:
            begin
                // Read the cell one row down, write the previous read one row up
                if (cnt_reg < CW'(MOVE))
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = AW'(cnt_reg + CW'(COLUMNS));
                    rd_pend_next = 1'b1;
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(cnt_reg - CW'(1));
                    mem_wdata = '{attr: text_attribute,
                                  ch:   rd_pend_reg ? mem_rdata.ch : 8'h00};
                end
                if (cnt_reg == CW'(CELLS))
                begin
                    cnt_next   = '0;
                    state_next = ST_PUT;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            ST_PUT:
            begin
                mem_we        = 1'b1;
                mem_waddr     = AW'(LAST_BASE);
                mem_wdata     = '{attr: text_attribute, ch: code_reg};
                cursor_x_next = adv_x;
                cursor_y_next = adv_y;
                state_next    = ST_FINISH;
            end

            ST_FINISH:
            begin
                // Load the report once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = {4'h0, 5'(cursor_y_reg), 7'(cursor_x_reg),
                                     report_cell.attr, report_cell.ch};
                    clr_op_next   = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            clr_op_reg   <= 1'b0;
            rd_hit_reg   <= 1'b0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            clr_op_reg   <= clr_op_next;
            rd_hit_reg   <= rd_hit_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    `TCW_ASSERT(a_cursor_on_screen, clk, rst_n,
        (XW1'(cursor_x_reg) < XW1'(COLUMNS)) && ((YW + 1)'(cursor_y_reg) < (YW + 1)'(ROWS)))
    `TCW_ASSERT(a_write_in_store, clk, rst_n,
        mem_we |-> (CW'(mem_waddr) < CW'(CELLS)))
    `TCW_ASSERT(a_no_same_cell_rw, clk, rst_n,
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    `TCW_ASSERT(a_report_from_finish, clk, rst_n,
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH))

endmodule

`default_nettype wire
